@@ rtl/u8sd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and constants of the UTF-8 stream decoder
// Holds the descriptor that the front part hands to the back part through
// the queue, and the fixed codes of the decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned USED_W  = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 2;
    localparam int unsigned NRES_W  = 3;

    localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [USED_W-1:0] USED_ONE       = 3'd1;

    localparam logic [BYTE_W-1:0] LEAD_MIN     = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_MAX     = 8'hF4;
    localparam logic [BYTE_W-1:0] CONT_F4_MAX  = 8'h90;
    localparam logic [1:0]        CONT_TAG     = 2'b10;

    localparam logic [USED_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [USED_W-1:0] LEN_THREE = 3'd3;
    localparam logic [USED_W-1:0] LEN_FOUR  = 3'd4;

    // One accepted item as the back part sees it: r_pos replacement
    // results, then the optional main result, then trailing replacements.
    typedef struct packed {
        logic [CP_W-1:0]   r_cp;
        logic [USED_W-1:0] r_used;
        logic              r_bad;
        logic              has_r;
        logic [CNT_W-1:0]  r_pos;
        logic [NRES_W-1:0] n_res;
        logic              eot;
    } desc_t;

endpackage
`default_nettype wire

@@ rtl/u8sd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_front: byte classifier and sequence tracker
// Accepts one byte per cycle while the queue has room, updates the held
// sequence and pushes a result descriptor for every item with a result.
// ----------------------------------------------------------------------------
module u8sd_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [u8sd_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic                          end_of_text,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          q_full,
    output logic                               q_push,
    output u8sd_pkg::desc_t                    q_data
);

    logic [u8sd_pkg::BYTE_W-1:0] held_reg  [3];
    logic [u8sd_pkg::BYTE_W-1:0] held_next [3];
    logic [u8sd_pkg::CNT_W-1:0]  count_reg;
    logic [u8sd_pkg::CNT_W-1:0]  count_next;
    logic [u8sd_pkg::USED_W-1:0] exp_reg;
    logic [u8sd_pkg::USED_W-1:0] exp_next;

    logic                         accept;
    logic                         is_cont;
    logic                         f_ascii;
    logic                         f_bad;
    logic [u8sd_pkg::USED_W-1:0]  f_exp;
    logic                         do_fresh;
    logic                         over_range;
    logic [u8sd_pkg::CP_W-1:0]    assembled;
    logic [u8sd_pkg::CNT_W-1:0]   k1;
    logic [u8sd_pkg::CNT_W-1:0]   k2;
    logic                         has_r;
    logic [u8sd_pkg::CP_W-1:0]    r_cp;
    logic [u8sd_pkg::USED_W-1:0]  r_used;
    logic                         r_bad;
    logic [u8sd_pkg::NRES_W-1:0]  n_res;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classification of the incoming byte on its own.
    assign is_cont = (data_byte[7:6] == u8sd_pkg::CONT_TAG);
    assign f_ascii = !data_byte[7];
    assign f_bad   = data_byte[7] &&
                     ((data_byte < u8sd_pkg::LEAD_MIN) || (data_byte > u8sd_pkg::LEAD_MAX));
    assign f_exp   = (data_byte < u8sd_pkg::LEAD3_MIN) ? u8sd_pkg::LEN_TWO :
                     (data_byte < u8sd_pkg::LEAD4_MIN) ? u8sd_pkg::LEN_THREE :
                                                         u8sd_pkg::LEN_FOUR;

    // A four-byte sequence led by F4 must stay at or below U+10FFFF.
    assign over_range = (exp_reg == u8sd_pkg::LEN_FOUR) &&
                        (held_reg[0] == u8sd_pkg::LEAD_MAX) &&
                        (held_reg[1] >= u8sd_pkg::CONT_F4_MAX);

    // Code point of the completed sequence, with the current byte last.
    always_comb
    begin
        case (exp_reg)
            u8sd_pkg::LEN_TWO:
            begin
                assembled = {10'd0, held_reg[0][4:0], data_byte[5:0]};
            end
            u8sd_pkg::LEN_THREE:
            begin
                assembled = {5'd0, held_reg[0][3:0], held_reg[1][5:0], data_byte[5:0]};
            end
            default:
            begin
                assembled = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                             data_byte[5:0]};
            end
        endcase
    end

    // Next state of the held sequence and the results of this item.
    always_comb
    begin
        held_next  = held_reg;
        count_next = count_reg;
        exp_next   = exp_reg;
        k1         = '0;
        k2         = '0;
        has_r      = 1'b0;
        r_cp       = u8sd_pkg::REPLACEMENT_CP;
        r_used     = u8sd_pkg::USED_ONE;
        r_bad      = 1'b1;
        do_fresh   = 1'b0;

        if (count_reg == '0)
        begin
            do_fresh = 1'b1;
        end
        else if (is_cont)
        begin
            if (({1'b0, count_reg} + 3'd1) >= exp_reg)
            begin
                if (over_range)
                begin
                    k1    = count_reg;
                    has_r = 1'b1;
                end
                else
                begin
                    has_r  = 1'b1;
                    r_cp   = assembled;
                    r_used = exp_reg;
                    r_bad  = 1'b0;
                end
                count_next = '0;
                exp_next   = '0;
            end
            else
            begin
                held_next[count_reg] = data_byte;
                count_next           = count_reg + 2'd1;
            end
        end
        else
        begin
            // Broken sequence: every held byte is replaced, then a fresh start.
            k1         = count_reg;
            count_next = '0;
            exp_next   = '0;
            do_fresh   = 1'b1;
        end

        if (do_fresh)
        begin
            if (f_ascii)
            begin
                has_r  = 1'b1;
                r_cp   = {13'd0, data_byte};
                r_bad  = 1'b0;
            end
            else if (f_bad)
            begin
                has_r = 1'b1;
            end
            else
            begin
                held_next[0] = data_byte;
                count_next   = 2'd1;
                exp_next     = f_exp;
            end
        end

        // End of text flushes whatever is still held.
        if (end_of_text)
        begin
            k2         = count_next;
            count_next = '0;
            exp_next   = '0;
        end
    end

    assign n_res = {1'b0, k1} + {2'b00, has_r} + {1'b0, k2};

    assign q_push        = accept && (n_res != '0);
    assign q_data.r_cp   = r_cp;
    assign q_data.r_used = r_used;
    assign q_data.r_bad  = r_bad;
    assign q_data.has_r  = has_r;
    assign q_data.r_pos  = k1;
    assign q_data.n_res  = n_res;
    assign q_data.eot    = end_of_text;

    // Sequence control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            exp_reg   <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            exp_reg   <= exp_next;
        end
    end

    // Held bytes carry no reset; only entries below the count are read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/u8sd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_queue: descriptor queue between front and back
// A small circular buffer that lets the classifier run ahead while the
// result side expands a multi-result item or waits on the consumer.
// ----------------------------------------------------------------------------
module u8sd_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire u8sd_pkg::desc_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output u8sd_pkg::desc_t      head_data
);

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    u8sd_pkg::desc_t     mem [DEPTH];
    logic [ADDR_W-1:0]   wr_ptr_reg;
    logic [ADDR_W-1:0]   wr_ptr_next;
    logic [ADDR_W-1:0]   rd_ptr_reg;
    logic [ADDR_W-1:0]   rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (fill_reg == FULL_FILL);
    assign empty     = (fill_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = mem[rd_ptr_reg];

    // Pointer and fill level updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + ADDR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + ADDR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/u8sd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_back: result expander
// Walks the head descriptor into a registered output stage, one result per
// cycle unless stalled, flagging the last result of each item and of the text.
// ----------------------------------------------------------------------------
module u8sd_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire u8sd_pkg::desc_t               head_data,
    input  wire logic                          q_empty,
    output logic                               q_pop,
    output logic [u8sd_pkg::CP_W-1:0]          code_point,
    output logic [u8sd_pkg::USED_W-1:0]        bytes_used,
    output logic                               malformed,
    output logic                               last_in_run,
    output logic                               text_done,
    output logic                               out_valid,
    input  wire logic                          out_ready
);

    logic [u8sd_pkg::CNT_W-1:0]  idx_reg;
    logic [u8sd_pkg::CNT_W-1:0]  idx_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [u8sd_pkg::CP_W-1:0]   cp_reg;
    logic [u8sd_pkg::USED_W-1:0] used_reg;
    logic                        bad_reg;
    logic                        last_reg;
    logic                        done_reg;

    logic                        load;
    logic                        is_main;
    logic                        is_last;

    assign load    = !q_empty && (!out_valid_reg || out_ready);
    assign is_main = head_data.has_r && (idx_reg == head_data.r_pos);
    assign is_last = ({1'b0, idx_reg} == (head_data.n_res - 3'd1));
    assign q_pop   = load && is_last;

    // Result index within the head item and output stage occupancy.
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = is_last ? '0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= is_main ? head_data.r_cp   : u8sd_pkg::REPLACEMENT_CP;
            used_reg <= is_main ? head_data.r_used : u8sd_pkg::USED_ONE;
            bad_reg  <= is_main ? head_data.r_bad  : 1'b1;
            last_reg <= is_last;
            done_reg <= is_last && head_data.eot;
        end
    end

    assign code_point  = cp_reg;
    assign bytes_used  = used_reg;
    assign malformed   = bad_reg;
    assign last_in_run = last_reg;
    assign text_done   = done_reg;
    assign out_valid   = out_valid_reg;

endmodule
`default_nettype wire

@@ rtl/utf8_stream_decoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top: UTF-8 byte stream to code point decoder
// Front classifier, descriptor queue and result expander.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | data_byte, end_of_text
//  output  | out_valid/ out_ready | code_point, bytes_used, malformed,
//          |                      | last_in_run, text_done
//
// One byte is accepted per cycle while the queue has room. An item with up
// to one result sustains one item per cycle while the output is not stalled;
// an item with several results holds the expander until its last result is
// out, and the queue absorbs such bursts. A first result passes the queue
// storage, then the output register. Reset clears the held count, the queue
// and the output stage; no clearing pass is needed.
//
module utf8_stream_decoder_top
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_text,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic [20:0]      code_point,
    output logic [2:0]       bytes_used,
    output logic             malformed,
    output logic             last_in_run,
    output logic             text_done,
    output logic             out_valid,
    input  wire logic        out_ready
);

    u8sd_pkg::desc_t push_data;
    u8sd_pkg::desc_t head_data;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;

    // Byte classifier and sequence tracker.
    u8sd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (push_data)
    );

    // Descriptor queue.
    u8sd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_data (head_data)
    );

    // Result expander and output register.
    u8sd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_data   (head_data),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .code_point  (code_point),
        .bytes_used  (bytes_used),
        .malformed   (malformed),
        .last_in_run (last_in_run),
        .text_done   (text_done),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule
`default_nettype wire
